/* rtl/asdp_pkg.sv */
// Shared types and constants for the audio stream descriptor parser.
package asdp_pkg;

  localparam logic [7:0] KIND_INTERFACE     = 8'h04;
  localparam logic [7:0] KIND_CS_IFACE      = 8'h24;
  localparam logic [7:0] SUB_STREAM_GENERAL = 8'h01;
  localparam logic [7:0] SUB_FORMAT_TYPE    = 8'h02;
  localparam logic [7:0] FMT_TYPE_I         = 8'h01;
  localparam logic [15:0] TAG_PCM           = 16'h0001;
  localparam logic [7:0] GENERAL_LEN        = 8'd7;
  localparam logic [7:0] FORMAT_MIN_LEN     = 8'd8;
  localparam logic [7:0] FORMAT_LEN         = 8'd11;
  localparam logic [7:0] MAX_SUBFRAME       = 8'd4;
  localparam logic [7:0] MIN_DESC_LEN       = 8'd2;
  localparam logic [7:0] ONE_RATE           = 8'd1;

  // Byte offsets within a descriptor
  localparam logic [7:0] POS_LENGTH   = 8'd0;
  localparam logic [7:0] POS_KIND     = 8'd1;
  localparam logic [7:0] POS_SUBKIND  = 8'd2;
  localparam logic [7:0] POS_FMT_TYPE = 8'd3;
  localparam logic [7:0] POS_NR_CH    = 8'd4;
  localparam logic [7:0] POS_SUBFRAME = 8'd5;
  localparam logic [7:0] POS_BITS     = 8'd6;
  localparam logic [7:0] POS_NR_RATES = 8'd7;
  localparam logic [7:0] POS_RATE_LO  = 8'd8;
  localparam logic [7:0] POS_RATE_MID = 8'd9;
  localparam logic [7:0] POS_RATE_HI  = 8'd10;
  localparam logic [7:0] POS_TAG_LO   = 8'd5;
  localparam logic [7:0] POS_TAG_HI   = 8'd6;

  // Field slots of the captured FORMAT_TYPE descriptor
  localparam int FLD_FMT_TYPE = 0;
  localparam int FLD_NR_CH    = 1;
  localparam int FLD_SUBFRAME = 2;
  localparam int FLD_BITS     = 3;
  localparam int FLD_NR_RATES = 4;

  typedef struct packed {
    logic [7:0]       position;
    logic [7:0]       length;
    logic [7:0]       kind;
    logic [7:0]       subkind;
    logic             failed;
    logic             general_seen;
    logic             format_seen;
    logic [7:0]       general_size;
    logic [7:0]       format_size;
    logic [15:0]      tag_word;
    logic [4:0][7:0]  fields;
    logic [23:0]      rate;
  } walk_state_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  channel_count;
    logic [2:0]  subframe_size;
    logic [5:0]  sample_bits;
    logic [23:0] sample_rate;
  } result_t;

endpackage

/* rtl/asdp_walker.sv */
// Descriptor walker: tracks boundaries and captures stream-general and format-type bytes.
module asdp_walker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  output asdp_pkg::walk_state_t state_post
);

  asdp_pkg::walk_state_t s_r;
  asdp_pkg::walk_state_t s_nxt;
  logic                  adv_pos;
  logic [7:0]            pos_p1;

  always_comb begin
    s_nxt   = s_r;
    adv_pos = 1'b0;
    pos_p1  = 8'd0;
    if (step && !s_r.failed) begin
      adv_pos = 1'b1;
      if (s_r.position == asdp_pkg::POS_LENGTH) begin
        if (data_byte < asdp_pkg::MIN_DESC_LEN) begin
          s_nxt.failed = 1'b1;
          adv_pos      = 1'b0;
        end else begin
          s_nxt.length  = data_byte;
          s_nxt.kind    = 8'd0;
          s_nxt.subkind = 8'd0;
        end
      end else if (s_r.position == asdp_pkg::POS_KIND) begin
        if (data_byte == asdp_pkg::KIND_INTERFACE) begin
          s_nxt.failed = 1'b1;
          adv_pos      = 1'b0;
        end else begin
          s_nxt.kind = data_byte;
        end
      end else if (s_r.position == asdp_pkg::POS_SUBKIND) begin
        s_nxt.subkind = data_byte;
        if (s_r.kind == asdp_pkg::KIND_CS_IFACE) begin
          if (data_byte == asdp_pkg::SUB_STREAM_GENERAL) begin
            if (s_r.general_seen) begin
              s_nxt.failed = 1'b1;
              adv_pos      = 1'b0;
            end else begin
              s_nxt.general_seen = 1'b1;
              s_nxt.general_size = s_r.length;
            end
          end else if (data_byte == asdp_pkg::SUB_FORMAT_TYPE) begin
            if (s_r.format_seen) begin
              s_nxt.failed = 1'b1;
              adv_pos      = 1'b0;
            end else begin
              s_nxt.format_seen = 1'b1;
              s_nxt.format_size = s_r.length;
            end
          end
        end
      end else if (s_r.kind == asdp_pkg::KIND_CS_IFACE) begin
        if (s_r.subkind == asdp_pkg::SUB_STREAM_GENERAL) begin
          if (s_r.position == asdp_pkg::POS_TAG_LO) begin
            s_nxt.tag_word[7:0] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_TAG_HI) begin
            s_nxt.tag_word[15:8] = data_byte;
          end
        end else if (s_r.subkind == asdp_pkg::SUB_FORMAT_TYPE) begin
          if (s_r.position == asdp_pkg::POS_FMT_TYPE) begin
            s_nxt.fields[asdp_pkg::FLD_FMT_TYPE] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_NR_CH) begin
            s_nxt.fields[asdp_pkg::FLD_NR_CH] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_SUBFRAME) begin
            s_nxt.fields[asdp_pkg::FLD_SUBFRAME] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_BITS) begin
            s_nxt.fields[asdp_pkg::FLD_BITS] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_NR_RATES) begin
            s_nxt.fields[asdp_pkg::FLD_NR_RATES] = data_byte;
          end else if (s_r.position == asdp_pkg::POS_RATE_LO) begin
            s_nxt.rate[7:0] = s_r.rate[7:0] | data_byte;
          end else if (s_r.position == asdp_pkg::POS_RATE_MID) begin
            s_nxt.rate[15:8] = s_r.rate[15:8] | data_byte;
          end else if (s_r.position == asdp_pkg::POS_RATE_HI) begin
            s_nxt.rate[23:16] = s_r.rate[23:16] | data_byte;
          end
        end
      end
      // boundary compare uses the length just taken on a length byte
      if (adv_pos) begin
        pos_p1         = s_r.position + 8'd1;
        s_nxt.position = (pos_p1 == s_nxt.length) ? 8'd0 : pos_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (step && final_byte) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign state_post = s_nxt;

endmodule

/* rtl/asdp_check.sv */
// End-of-block format check and result formation.
module asdp_check (
  input  asdp_pkg::walk_state_t state_post,
  output asdp_pkg::result_t     result
);

  logic [7:0] sub;
  logic [7:0] bits;
  logic [7:0] bits_max;
  logic       valid;

  always_comb begin
    sub      = state_post.fields[asdp_pkg::FLD_SUBFRAME];
    bits     = state_post.fields[asdp_pkg::FLD_BITS];
    bits_max = {sub[4:0], 3'b000};
    valid = !state_post.failed
         && (state_post.position == asdp_pkg::POS_LENGTH)
         && state_post.general_seen
         && (state_post.general_size == asdp_pkg::GENERAL_LEN)
         && state_post.format_seen
         && (state_post.tag_word == asdp_pkg::TAG_PCM)
         && (state_post.format_size >= asdp_pkg::FORMAT_MIN_LEN)
         && (state_post.fields[asdp_pkg::FLD_FMT_TYPE] == asdp_pkg::FMT_TYPE_I)
         && (state_post.fields[asdp_pkg::FLD_NR_RATES] == asdp_pkg::ONE_RATE)
         && (state_post.format_size == asdp_pkg::FORMAT_LEN)
         && (state_post.fields[asdp_pkg::FLD_NR_CH] != 8'd0)
         && (sub != 8'd0) && (sub <= asdp_pkg::MAX_SUBFRAME)
         && (bits != 8'd0) && (bits <= bits_max)
         && (state_post.rate != 24'd0);

    result = '0;
    if (valid) begin
      result.ok            = 1'b1;
      result.channel_count = state_post.fields[asdp_pkg::FLD_NR_CH];
      result.subframe_size = sub[2:0];
      result.sample_bits   = bits[5:0];
      result.sample_rate   = state_post.rate;
    end
  end

endmodule

/* rtl/audio_stream_descriptor_parser_unit.sv */
// Top level of the audio stream descriptor parser: input stage, walker, check, result register.
//
//   channel | ports                                          | direction
//   in      | in_valid/in_ready, in_data_byte, in_final_byte | byte stream in
//   out     | out_valid/out_ready, out_ok + format fields    | one result per block
//
// One byte per cycle unless a final byte waits; results are taken into the result register.
// Only a final byte produces a result; other bytes never stall.
// A final byte waits in the input stage while the result register is full and unread.
// Synchronous active-low reset returns the walker to the start of a block.
module audio_stream_descriptor_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [7:0]  out_channel_count,
  output logic [2:0]  out_subframe_size,
  output logic [5:0]  out_sample_bits,
  output logic [23:0] out_sample_rate
);

  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  in_final_r;
  logic                  advance;
  logic                  step;
  logic                  out_v_r;
  logic                  out_v_nxt;
  asdp_pkg::result_t     res_r;
  asdp_pkg::result_t     res_nxt;
  asdp_pkg::walk_state_t state_post;

  // a final byte can only leave once the result slot is free or being read
  assign advance  = !(in_final_r && out_v_r && !out_ready);
  assign step     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r  <= in_data_byte;
      in_final_r <= in_final_byte;
    end
  end

  asdp_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_byte_r),
    .final_byte (in_final_r),
    .state_post (state_post)
  );

  asdp_check u_check (
    .state_post (state_post),
    .result     (res_nxt)
  );

  always_comb begin
    out_v_nxt = out_v_r && !out_ready;
    if (step && in_final_r) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_final_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_ok            = res_r.ok;
  assign out_channel_count = res_r.channel_count;
  assign out_subframe_size = res_r.subframe_size;
  assign out_sample_bits   = res_r.sample_bits;
  assign out_sample_rate   = res_r.sample_rate;

`ifndef SYNTHESIS
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && in_final_r && out_valid && !out_ready))
    else $error("input stalled without a pending result");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_channel_count == 8'd0 && out_subframe_size == 3'd0
      && out_sample_bits == 6'd0 && out_sample_rate == 24'd0))
    else $error("failed result carries nonzero fields");

  a_ok_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok) |-> (out_subframe_size != 3'd0 && out_subframe_size <= 3'd4
      && out_sample_bits != 6'd0 && out_sample_rate != 24'd0 && out_channel_count != 8'd0))
    else $error("ok result with out-of-range fields");

  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> ($past(in_v_r) && $past(in_final_r)))
    else $error("result appeared without a final byte");
`endif

endmodule
